@@ hdl/agr_pkg.sv @@
// Package for the alternate group reverser: sizes, command and buffer-port types.
// Used by agr_front, agr_cmdq, agr_back and alternate_group_reverser.
`timescale 1ns / 1ps

package agr_pkg;

  localparam int MAX_GROUP  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int GS_W       = 7;                          // group_size register width
  localparam int CNT_W      = $clog2(MAX_GROUP + 1);      // counts 0..MAX_GROUP
  localparam int ADDR_W     = $clog2(MAX_GROUP);          // entry within one bank
  localparam int BUF_AW     = ADDR_W + 1;                 // bank select + entry
  localparam int BUF_DEPTH  = 2 * MAX_GROUP;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Work for the back end
  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,   // send the carried word as is
    CMD_REV  = 2'd1,   // drain a full bank, newest entry first
    CMD_FWD  = 2'd2    // drain a partial bank, oldest entry first
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   bank;
    logic [CNT_W-1:0]       cnt;
    logic [DATA_WIDTH-1:0]  value;
    logic                   last;
  } cmd_t;

  // Buffer write from the front end
  typedef struct packed {
    logic                   en;
    logic [BUF_AW-1:0]      addr;
    logic [DATA_WIDTH-1:0]  data;
  } buf_wr_t;

  // Bank release from the back end
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  // One result word
  typedef struct packed {
    logic [DATA_WIDTH-1:0]  value;
    logic                   run_end;
    logic                   stream_end;
  } res_t;

endpackage

@@ hdl/agr_front.sv @@
// Front end: accepts input words, fills the ping-pong banks and issues commands.
// Depends on agr_pkg.
`timescale 1ns / 1ps

module agr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [agr_pkg::GS_W-1:0]     group_size,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [agr_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                         in_last,
  output logic                         cmd_push,
  output agr_pkg::cmd_t                cmd,
  input  logic                         cmd_full,
  output agr_pkg::buf_wr_t             buf_wr,
  input  agr_pkg::bank_rel_t           bank_rel
);
  import agr_pkg::*;

  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] pass_r, pass_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic [1:0]       busy_set;
  logic [CNT_W-1:0] g_eff;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] pass_inc;
  logic             acc;

  // Clamp the group size to 1..MAX_GROUP
  always_comb begin
    if (group_size == '0) begin
      g_eff = CNT_W'(1);
    end else if (group_size > GS_W'(MAX_GROUP)) begin
      g_eff = CNT_W'(MAX_GROUP);
    end else begin
      g_eff = CNT_W'(group_size);
    end
  end

  // Stall while the command queue is full or the bank to fill is still draining
  assign in_full  = cmd_full | (~phase_r & busy_r[bank_r]);
  assign acc      = in_push & ~in_full;
  assign fill_inc = fill_r + CNT_W'(1);
  assign pass_inc = pass_r + CNT_W'(1);

  // Classify the accepted word
  always_comb begin
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    pass_nxt    = pass_r;
    bank_nxt    = bank_r;
    busy_set    = '0;
    cmd_push    = 1'b0;
    cmd.kind    = CMD_PASS;
    cmd.bank    = bank_r;
    cmd.cnt     = fill_inc;
    cmd.value   = in_value;
    cmd.last    = in_last;
    buf_wr.en   = 1'b0;
    buf_wr.addr = {bank_r, fill_r[ADDR_W-1:0]};
    buf_wr.data = in_value;
    if (acc) begin
      if (phase_r) begin
        cmd_push = 1'b1;
        cmd.kind = CMD_PASS;
        if (pass_inc >= g_eff) begin
          phase_nxt = 1'b0;
          pass_nxt  = '0;
        end else begin
          pass_nxt  = pass_inc;
        end
      end else begin
        buf_wr.en = 1'b1;
        if (fill_inc >= g_eff) begin
          cmd_push         = 1'b1;
          cmd.kind         = CMD_REV;
          fill_nxt         = '0;
          phase_nxt        = 1'b1;
          pass_nxt         = '0;
          bank_nxt         = ~bank_r;
          busy_set[bank_r] = 1'b1;
        end else if (in_last) begin
          cmd_push         = 1'b1;
          cmd.kind         = CMD_FWD;
          fill_nxt         = '0;
          bank_nxt         = ~bank_r;
          busy_set[bank_r] = 1'b1;
        end else begin
          fill_nxt         = fill_inc;
        end
      end
      // End of stream: start over with a reversed group
      if (in_last) begin
        phase_nxt = 1'b0;
        fill_nxt  = '0;
        pass_nxt  = '0;
      end
    end
  end

  // Track banks that hold a pending drain
  always_comb begin
    busy_nxt = busy_r | busy_set;
    if (bank_rel.en) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      fill_r  <= '0;
      pass_r  <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      pass_r  <= pass_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

@@ hdl/agr_cmdq.sv @@
// Command queue between the front and back ends.
// Depends on agr_pkg.
`timescale 1ns / 1ps

module agr_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  agr_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output agr_pkg::cmd_t dout,
  output logic          empty
);
  import agr_pkg::*;

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, rp_r;
  logic [CMDQ_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = q_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= din;
    end
  end

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CMDQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CMDQ_CW'(1);
      end
    end
  end

endmodule

@@ hdl/agr_back.sv @@
// Back end: holds the group buffer, runs commands one word per cycle while the result queue has room, queues results.
// Depends on agr_pkg.
`timescale 1ns / 1ps

module agr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  agr_pkg::buf_wr_t     buf_wr,
  input  agr_pkg::cmd_t        cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output agr_pkg::bank_rel_t   bank_rel,
  output agr_pkg::res_t        res,
  output logic                 res_empty,
  input  logic                 res_pop
);
  import agr_pkg::*;

  logic [DATA_WIDTH-1:0] mem [BUF_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_m1;
  logic [CNT_W-1:0]      rev_idx;
  logic [BUF_AW-1:0]     rd_addr;
  logic                  issue;
  logic                  last_beat;
  logic                  space;

  logic                  s1_vld_r;
  logic                  s1_mem_r;
  logic [DATA_WIDTH-1:0] s1_value_r;
  logic                  s1_run_end_r;
  logic                  s1_stream_end_r;
  res_t                  s1_res;

  res_t                  oq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]    owp_r, orp_r;
  logic [OUTQ_CW-1:0]    ocnt_r;
  logic                  o_pop;

  // Issue only with room for the word in flight
  assign space  = ({1'b0, ocnt_r} + {{OUTQ_CW{1'b0}}, s1_vld_r}) <= (OUTQ_CW + 1)'(OUTQ_DEPTH - 1);
  assign issue  = ~cmd_empty & space;
  assign cnt_m1 = cmd.cnt - CNT_W'(1);
  assign rev_idx = cnt_m1 - pos_r;

  // Decode the head command
  always_comb begin
    unique case (cmd.kind)
      CMD_PASS: begin
        last_beat = 1'b1;
        rd_addr   = {cmd.bank, pos_r[ADDR_W-1:0]};
      end
      CMD_REV: begin
        last_beat = (pos_r == cnt_m1);
        rd_addr   = {cmd.bank, rev_idx[ADDR_W-1:0]};
      end
      CMD_FWD: begin
        last_beat = (pos_r == cnt_m1);
        rd_addr   = {cmd.bank, pos_r[ADDR_W-1:0]};
      end
      default: begin
        last_beat = 1'b1;
        rd_addr   = {cmd.bank, pos_r[ADDR_W-1:0]};
      end
    endcase
  end

  assign cmd_pop       = issue & last_beat;
  assign bank_rel.en   = cmd_pop & (cmd.kind != CMD_PASS);
  assign bank_rel.bank = cmd.bank;
  assign pos_nxt       = issue ? (last_beat ? '0 : pos_r + CNT_W'(1)) : pos_r;

  // Group buffer: front end writes, back end reads
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold the payload of the word in flight
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_mem_r        <= (cmd.kind != CMD_PASS);
      s1_value_r      <= cmd.value;
      s1_run_end_r    <= last_beat;
      s1_stream_end_r <= last_beat & cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      s1_vld_r <= issue;
    end
  end

  assign s1_res.value      = s1_mem_r ? rd_data_r : s1_value_r;
  assign s1_res.run_end    = s1_run_end_r;
  assign s1_res.stream_end = s1_stream_end_r;

  // Result queue
  assign res_empty = (ocnt_r == '0);
  assign res       = oq_r[orp_r];
  assign o_pop     = res_pop & ~res_empty;

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      oq_r[owp_r] <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (s1_vld_r) begin
        owp_r <= owp_r + OUTQ_AW'(1);
      end
      if (o_pop) begin
        orp_r <= orp_r + OUTQ_AW'(1);
      end
      if (s1_vld_r && !o_pop) begin
        ocnt_r <= ocnt_r + OUTQ_CW'(1);
      end else if (o_pop && !s1_vld_r) begin
        ocnt_r <= ocnt_r - OUTQ_CW'(1);
      end
    end
  end

endmodule

@@ hdl/alternate_group_reverser.sv @@
// Alternate group reverser: top level with the group_size register.
// A passed word goes through the command queue, the read stage and the result queue;
// a reversed group drains newest word first.
// Throughput: one word per cycle in and out; the back end emits one word per cycle with
// room in the result queue; input stalls only if the bank to fill drains or cmdq is full.
// Reset (rst_n low, synchronous): group_size is 1, queues empty, reversing phase first.
`timescale 1ns / 1ps

module alternate_group_reverser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_value,
  input  logic                in_last,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_value,
  output logic                out_run_end,
  output logic                out_stream_end
);
  import agr_pkg::*;

  logic [GS_W-1:0] group_size_r;
  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_pop;
  logic            cmd_empty;
  cmd_t            cmd_in;
  cmd_t            cmd_out;
  buf_wr_t         buf_wr;
  bank_rel_t       bank_rel;
  res_t            res;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      group_size_r <= cfg_data;
    end
  end

  agr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .group_size (group_size_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_value   ($unsigned(in_value)),
    .in_last    (in_last),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full),
    .buf_wr     (buf_wr),
    .bank_rel   (bank_rel)
  );

  agr_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  agr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_wr    (buf_wr),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .bank_rel  (bank_rel),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  // Drive the result ports
  assign out_value      = $signed(res.value);
  assign out_run_end    = res.run_end;
  assign out_stream_end = res.stream_end;

endmodule

@@ sim/tb_alternate_group_reverser.sv @@
// Testbench for alternate_group_reverser: queue-style stimulus, a clocked driver and
// monitor, and a cycle-free predictor of the group reordering. Depends on agr_pkg.
`timescale 1ns / 1ps

module tb_alternate_group_reverser;
  import agr_pkg::*;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off for back pressure
  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int SETTLE_WAIT = 8;     // extra wait after the last predicted word came out

  typedef struct {
    logic signed [31:0] value;
    logic               last;
  } in_word_t;

  typedef struct {
    logic signed [31:0] value;
    logic               run_end;
    logic               stream_end;
  } out_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_data = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [31:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_value;
  logic               out_run_end;
  logic               out_stream_end;

  // Stimulus and prediction state
  in_word_t   send_q[$];
  out_word_t  reordered_q[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         holds_asked = 0;
  int         holds_done = 0;
  int         hold_left = 0;
  logic       in_took = 1'b0;

  // Predictor's copy of the block
  logic [6:0]         grp_size = 7'd1;
  logic signed [31:0] held[MAX_GROUP];
  int                 fill_cnt = 0;
  logic               passing = 1'b0;
  int                 pass_cnt = 0;

  // Run statistics
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int burst_len = 0;
  int longest_burst = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  alternate_group_reverser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_value      (out_value),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end)
  );

  always #5 clk = ~clk;

  // Queue one predicted result word
  function automatic void add_result(logic signed [31:0] v, logic run_end, logic stream_end);
    out_word_t r;
    r.value = v;
    r.run_end = run_end;
    r.stream_end = stream_end;
    reordered_q.push_back(r);
  endfunction

  // Advance the reorder state by one accepted word and queue what it releases
  function automatic void reorder_word(logic signed [31:0] v, logic last);
    int g;
    int i;
    g = (grp_size == 0) ? 1 : ((grp_size > MAX_GROUP) ? MAX_GROUP : int'(grp_size));
    if (passing) begin
      add_result(v, 1'b1, last);
      pass_cnt = (pass_cnt + 1) & 'h7f;
      if (pass_cnt >= g) begin
        passing = 1'b0;
        pass_cnt = 0;
      end
    end else begin
      if (fill_cnt < MAX_GROUP) begin
        held[fill_cnt] = v;
        fill_cnt++;
      end
      if (fill_cnt >= g) begin
        // complete group: drain newest first
        for (i = fill_cnt; i > 0; i--)
          add_result(held[i-1], i == 1, (i == 1) && last);
        fill_cnt = 0;
        passing = 1'b1;
        pass_cnt = 0;
      end else if (last) begin
        // stream ended inside a partial group: drain in arrival order
        for (i = 0; i < fill_cnt; i++)
          add_result(held[i], i + 1 == fill_cnt, i + 1 == fill_cnt);
        fill_cnt = 0;
      end
    end
    if (last) begin
      fill_cnt = 0;
      passing = 1'b0;
      pass_cnt = 0;
    end
  endfunction

  // Drive input words from the send queue; hold a word until it is taken
  always @(negedge clk) begin : drive_words
    in_word_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_took) begin
      if (send_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = send_q.pop_front();
        in_push  <= 1'b1;
        in_value <= nxt.value;
        in_last  <= nxt.last;
      end else begin
        in_push  <= 1'b0;
        in_value <= $urandom;
        in_last  <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Pop result words; run a long hold-off when one is asked for
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Predict on each accepted input word, check each accepted result word
  always @(posedge clk) begin : watch_ports
    out_word_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_push && !in_full;
      if (in_push && !in_full) begin
        reorder_word(in_value, in_last);
        words_in++;
      end
      if (out_pop && !out_empty) begin
        words_out++;
        burst_len++;
        if (out_run_end) begin
          if (burst_len > longest_burst)
            longest_burst = burst_len;
          burst_len = 0;
        end
        if (reordered_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word value=%0d run_end=%0b stream_end=%0b",
                   $time, out_value, out_run_end, out_stream_end);
        end else begin
          want = reordered_q.pop_front();
          if (out_value !== want.value) begin
            errors++;
            $display("%0t: value expected %0d got %0d", $time, want.value, out_value);
          end
          if (out_run_end !== want.run_end) begin
            errors++;
            $display("%0t: run_end expected %0b got %0b", $time, want.run_end, out_run_end);
          end
          if (out_stream_end !== want.stream_end) begin
            errors++;
            $display("%0t: stream_end expected %0b got %0b",
                     $time, want.stream_end, out_stream_end);
          end
        end
      end
    end
  end

  // Stop the run when no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d words still due", $time, reordered_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_word(logic signed [31:0] v, logic last);
    in_word_t w;
    w.value = v;
    w.last = last;
    send_q.push_back(w);
  endtask

  // Queue n random words; close the stream with in_last when asked
  task automatic queue_stream(int n, bit close);
    int i;
    logic signed [31:0] v;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       v = 32'sh7fffffff;
        1:       v = 32'sh80000000;
        2:       v = 32'sh0;
        3:       v = -32'sd1;
        default: v = $urandom;
      endcase
      add_word(v, close && (i == n - 1));
    end
  endtask

  // Wait until every queued word went in and every predicted word came out
  task automatic settle();
    @(posedge clk);
    while (send_q.size() > 0 || in_push || reordered_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_group_size(logic [6:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    grp_size = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 7'($urandom);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 31; recv_idle_pct = 45; end
      1: begin send_idle_pct = 45; recv_idle_pct = 31; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  initial begin
    int mode;
    int p;
    int g;
    int budget;
    int len;
    logic [6:0] sizes[9];

    sizes = '{7'd127, 7'd2, 7'd5, 7'd64, 7'd1, 7'd3, 7'd0, 7'd6, 7'd0};
    sizes[8] = 7'($urandom_range(1, 127));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: pass-through at the reset size, field extremes
    set_idling(2);
    add_word(32'sh7fffffff, 1'b0);
    add_word(32'sh80000000, 1'b0);
    add_word(32'sh0, 1'b0);
    add_word(-32'sd1, 1'b1);
    settle();

    // Size zero behaves as one
    write_group_size(7'd0);
    add_word(32'sd5, 1'b0);
    add_word(32'sd6, 1'b1);
    settle();

    // Full group, pass group ending the stream, partial group at the end,
    // full group that is also the last one
    write_group_size(7'd3);
    for (int i = 1; i <= 11; i++)
      add_word(i, (i == 6) || (i == 8) || (i == 11));
    settle();

    // Shrink the size while a reversed group is half filled
    write_group_size(7'd4);
    add_word(32'sd21, 1'b0);
    add_word(32'sd22, 1'b0);
    settle();
    write_group_size(7'd2);
    add_word(32'sd23, 1'b0);
    add_word(32'sd24, 1'b0);
    add_word(32'sd25, 1'b1);
    settle();

    // Random streams under three idling patterns and several sizes
    for (mode = 0; mode < 3; mode++) begin
      set_idling(mode);
      for (p = 0; p < 3; p++) begin
        write_group_size(sizes[mode * 3 + p]);
        g = (grp_size == 0) ? 1 : ((grp_size > MAX_GROUP) ? MAX_GROUP : int'(grp_size));
        budget = (g >= 32) ? 40 : 18;
        while (budget > 0) begin
          len = $urandom_range(1, 3 * g + 1);
          if (len > budget)
            len = budget;
          budget -= len;
          // now and then leave the stream open across the next size change
          queue_stream(len, (budget > 0) || ($urandom_range(0, 3) != 0));
        end
        settle();
      end
    end

    // Back pressure: hold the receiver while a large group streams in
    set_idling(2);
    write_group_size(7'd64);
    holds_asked++;
    queue_stream(100, 1'b1);
    settle();

    repeat (10) @(posedge clk);
    $display("covered %0d input words, %0d result words, longest burst %0d words",
             words_in, words_out, longest_burst);
    $display("%0d group size writes incl. 0, 1, 64 and 127; one %0d-cycle receiver hold",
             cfg_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
